// File: rtl/olp_pkg.sv
// Shared types, constants and parse helpers for the order message line parser.
// No dependencies; every rtl file imports this package.
package olp_pkg;

  localparam int SYMBOL_BYTES    = 8;
  localparam int FIELD_COUNT_CAP = 8;

  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] RSN_NONE     = 3'd0;
  localparam logic [2:0] RSN_UNKNOWN  = 3'd0;
  localparam logic [2:0] RSN_COUNT    = 3'd1;
  localparam logic [2:0] RSN_NONNUM   = 3'd2;
  localparam logic [2:0] RSN_RANGE    = 3'd3;
  localparam logic [2:0] RSN_SIDE     = 3'd4;
  localparam logic [2:0] RSN_TYPE     = 3'd5;
  localparam logic [2:0] RSN_PREC     = 3'd6;
  localparam logic [2:0] RSN_SYMLONG  = 3'd7;

  localparam logic [2:0] TOK_NEW    = 3'd0;
  localparam logic [2:0] TOK_CANCEL = 3'd1;
  localparam logic [2:0] TOK_BUY    = 3'd2;
  localparam logic [2:0] TOK_SELL   = 3'd3;
  localparam logic [2:0] TOK_MARKET = 3'd4;
  localparam logic [2:0] TOK_LIMIT  = 3'd5;

  // Match result codes: none, first or second token of a pair, or start
  localparam logic [1:0] MATCH_NONE   = 2'd0;
  localparam logic [1:0] MATCH_FIRST  = 2'd1;
  localparam logic [1:0] MATCH_SECOND = 2'd2;
  localparam logic [1:0] MATCH_START  = 2'd3;

  localparam logic [3:0] FIELD_HEAD   = 4'd0;
  localparam logic [3:0] FIELD_ID     = 4'd1;
  localparam logic [3:0] FIELD_SYMBOL = 4'd2;
  localparam logic [3:0] FIELD_SIDE   = 4'd3;
  localparam logic [3:0] FIELD_TYPE   = 4'd4;
  localparam logic [3:0] FIELD_QTY    = 4'd5;
  localparam logic [3:0] FIELD_PRICE  = 4'd6;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [63:0] I64_TOP      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PRICE_INT_MAX = I64_TOP / 64'd100;
  localparam logic [63:0] PRICE_DOT_MAX = I64_TOP / 64'd100 - 64'd100;

  typedef struct packed {
    logic stop;
    logic ovf;
    logic dig;
    logic neg;
  } num_flags_t;

  typedef struct packed {
    logic [3:0]       field_index;
    logic [1:0]       head_match;
    logic [1:0]       token_match;
    logic [63:0]      accum;
    num_flags_t       flags;
    logic [1:0]       frac_digits;
    logic [63:0]      saved_id;
    logic [63:0]      saved_qty;
    logic [63:0]      saved_price;
    logic [7:0][7:0]  symbols;
    logic [6:1][2:0]  errs;
    logic [3:0]       field_length;
    logic [3:0]       symbol_count;
    logic             dot_seen;
    logic             sell_seen;
    logic             limit_seen;
  } line_state_t;

  function automatic line_state_t line_clear();
    line_state_t s;
    s = '0;
    s.head_match  = MATCH_START;
    s.token_match = MATCH_START;
    return s;
  endfunction

  function automatic logic [3:0] tok_len(logic [2:0] t);
    logic [3:0] n;
    case (t)
      TOK_NEW:    n = 4'd3;
      TOK_CANCEL: n = 4'd6;
      TOK_BUY:    n = 4'd3;
      TOK_SELL:   n = 4'd4;
      TOK_MARKET: n = 4'd6;
      TOK_LIMIT:  n = 4'd5;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  // Character at pos of token t; text is right-justified, first char highest
  function automatic logic [7:0] tok_char(logic [2:0] t, logic [3:0] pos);
    logic [47:0] txt;
    logic [3:0]  n;
    logic [2:0]  slot;
    case (t)
      TOK_NEW:    txt = 48'("NEW");
      TOK_CANCEL: txt = 48'("CANCEL");
      TOK_BUY:    txt = 48'("BUY");
      TOK_SELL:   txt = 48'("SELL");
      TOK_MARKET: txt = 48'("MARKET");
      TOK_LIMIT:  txt = 48'("LIMIT");
      default:    txt = '0;
    endcase
    n    = tok_len(t);
    slot = 3'(n - 4'd1 - pos);
    return (pos < n) ? txt[{slot, 3'b000} +: 8] : 8'h00;
  endfunction

  function automatic logic [1:0] match_step(logic [1:0] mask, logic [2:0] base,
                                            logic [3:0] len, logic [7:0] c);
    logic [1:0] res;
    logic [2:0] t;
    res = '0;
    for (int k = 0; k < 2; k++) begin
      t = base + 3'(k);
      if (mask[k] && (len < tok_len(t)) && (tok_char(t, len) == c)) res[k] = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [1:0] match_end(logic [1:0] mask, logic [2:0] base,
                                           logic [3:0] len);
    logic [1:0] r;
    if (mask[0] && len == tok_len(base)) r = MATCH_FIRST;
    else if (mask[1] && len == tok_len(base + 3'd1)) r = MATCH_SECOND;
    else r = MATCH_NONE;
    return r;
  endfunction

  function automatic logic [2:0] num_eval(num_flags_t f, logic [63:0] acc, logic is_signed);
    logic [2:0] code;
    if (!f.dig) code = RSN_NONNUM;
    else if (f.ovf) code = RSN_RANGE;
    else if (is_signed && (acc > (f.neg ? I64_TOP + 64'd1 : I64_TOP))) code = RSN_RANGE;
    else if (f.stop) code = RSN_NONNUM;
    else code = RSN_NONE;
    return code;
  endfunction

  function automatic logic [63:0] num_value(num_flags_t f, logic [63:0] acc);
    return f.neg ? (64'd0 - acc) : acc;
  endfunction

  // Close the current field: evaluate it, then reset per-field state
  function automatic line_state_t field_finish(line_state_t s);
    line_state_t o;
    logic [2:0]  code;
    logic [1:0]  r;
    logic [63:0] v;
    o    = s;
    v    = num_value(s.flags, s.accum);
    code = '0;
    r    = '0;
    case (s.field_index)
      FIELD_HEAD: o.head_match = match_end(s.head_match, TOK_NEW, s.field_length);
      FIELD_ID, FIELD_QTY: begin
        code = num_eval(s.flags, s.accum, 1'b0);
        if (code != RSN_NONE) o.errs[s.field_index[2:0]] = code;
        else if (s.field_index == FIELD_ID) o.saved_id = v;
        else o.saved_qty = v;
      end
      FIELD_SYMBOL: begin
        o.symbol_count = s.field_length;
        if (s.field_length > 4'(SYMBOL_BYTES)) o.errs[2] = RSN_SYMLONG;
      end
      FIELD_SIDE: begin
        r = match_end(s.token_match, TOK_BUY, s.field_length);
        if (r == MATCH_NONE) o.errs[3] = RSN_SIDE;
        else o.sell_seen = (r == MATCH_SECOND);
      end
      FIELD_TYPE: begin
        r = match_end(s.token_match, TOK_MARKET, s.field_length);
        if (r == MATCH_NONE) o.errs[4] = RSN_TYPE;
        else o.limit_seen = (r == MATCH_SECOND);
      end
      FIELD_PRICE: begin
        if (s.errs[6] == RSN_NONE) begin
          code = num_eval(s.flags, s.accum, 1'b1);
          if (code != RSN_NONE) o.errs[6] = code;
          else if (!s.dot_seen) begin
            if (s.accum > PRICE_INT_MAX) o.errs[6] = RSN_RANGE;
            else o.saved_price = v * 64'd100;
          end else if (s.frac_digits > 2'd2) o.errs[6] = RSN_PREC;
          else if (s.frac_digits == 2'd1) o.saved_price = s.saved_price + v * 64'd10;
          else o.saved_price = s.saved_price + v;
        end
      end
      default: ;
    endcase
    o.field_length = '0;
    o.accum        = '0;
    o.flags        = '0;
    o.frac_digits  = '0;
    o.dot_seen     = 1'b0;
    o.token_match  = MATCH_START;
    return o;
  endfunction

endpackage

// File: rtl/olp_digit_acc.sv
// Decimal accumulator step: one character into a 64-bit value with overflow flag.
// Depends on olp_pkg.
module olp_digit_acc (
  input  logic [63:0]         accum,
  input  olp_pkg::num_flags_t flags,
  input  logic [7:0]          c,
  input  logic                may_sign,
  input  logic                first,
  output logic [63:0]         accum_next,
  output olp_pkg::num_flags_t flags_next
);
  import olp_pkg::*;

  logic [67:0] prod;
  logic [3:0]  d;

  assign d    = 4'(c - CHAR_ZERO);
  // accum*10 + d, wide enough to see a carry out of 64 bits
  assign prod = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {64'd0, d};

  always_comb begin
    accum_next = accum;
    flags_next = flags;
    if (!flags.stop) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        if (!flags.ovf) begin
          if (prod[67:64] != 4'd0) flags_next.ovf = 1'b1;
          else accum_next = prod[63:0];
        end
        flags_next.dig = 1'b1;
      end else if (may_sign && first && c == CHAR_MINUS) begin
        flags_next.neg = 1'b1;
      end else begin
        flags_next.stop = 1'b1;
      end
    end
  end

endmodule

// File: rtl/order_message_line_parser.sv
// Top level of the order message line parser: byte-wise field parse and line decision.
// Depends on olp_pkg and olp_digit_acc.
//
//  channel  signals                                   beat
//  -------  ----------------------------------------  ------------------------------
//  in       in_valid/in_ready, char_byte, last_byte,  one line character
//           session_id
//  out      out_valid/out_ready, kind, reason, ...,    one decision per line, issued
//           session_out                               after the beat with last_byte
//
// One byte is taken per cycle while in_ready is high; all per-byte work happens between the line state
// register and the result register, so throughput is one byte per clock unless in_ready drops.
// The decision for a line appears in the cycle after its last byte is accepted.
// in_ready drops only while a finished result waits and out_ready is low.
// rst clears the line state and the result valid flag.
module order_message_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        last_byte,
  input  logic [31:0] session_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  reason,
  output logic        id_known,
  output logic [63:0] order_id,
  output logic        side_sell,
  output logic        is_limit,
  output logic [63:0] quantity,
  output logic signed [63:0] price_cents,
  output logic [63:0] symbol_chars,
  output logic [3:0]  symbol_length,
  output logic [31:0] session_out
);
  import olp_pkg::*;

  line_state_t line_st, line_next;
  line_state_t after_byte, at_end;
  logic        accept;

  logic [63:0] acc_next;
  num_flags_t  flg_next;
  logic        acc_first;

  logic [1:0]  kind_next;
  logic [2:0]  reason_next;
  logic        id_known_next;
  logic [63:0] order_id_next;
  logic        side_next, limit_next;
  logic [63:0] qty_next, price_next, chars_next;
  logic [3:0]  symlen_next;
  logic [31:0] session_next;
  logic [4:0]  count;
  logic [2:0]  price_code;
  logic [63:0] price_v;

  // Hold in_ready while the result register is free or draining this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Price fraction opens its own sign position after the dot
  assign acc_first = line_st.dot_seen ? (line_st.frac_digits == 2'd0)
                                      : (line_st.field_length == 4'd0);

  olp_digit_acc u_acc (
    .accum      (line_st.accum),
    .flags      (line_st.flags),
    .c          (char_byte),
    .may_sign   (line_st.field_index == FIELD_PRICE),
    .first      (acc_first),
    .accum_next (acc_next),
    .flags_next (flg_next)
  );

  assign price_code = num_eval(line_st.flags, line_st.accum, 1'b1);
  assign price_v    = num_value(line_st.flags, line_st.accum);

  // Advance the line state by one byte
  always_comb begin
    after_byte = line_st;
    if (char_byte == CHAR_COMMA) begin
      after_byte = field_finish(line_st);
      if (line_st.field_index < 4'(FIELD_COUNT_CAP))
        after_byte.field_index = line_st.field_index + 4'd1;
    end else begin
      case (line_st.field_index)
        FIELD_HEAD: after_byte.head_match =
          match_step(line_st.head_match, TOK_NEW, line_st.field_length, char_byte);
        FIELD_ID, FIELD_QTY: begin
          after_byte.accum = acc_next;
          after_byte.flags = flg_next;
        end
        FIELD_SYMBOL: begin
          if (line_st.field_length < 4'(SYMBOL_BYTES))
            after_byte.symbols[line_st.field_length[2:0]] = char_byte;
        end
        FIELD_SIDE: after_byte.token_match =
          match_step(line_st.token_match, TOK_BUY, line_st.field_length, char_byte);
        FIELD_TYPE: after_byte.token_match =
          match_step(line_st.token_match, TOK_MARKET, line_st.field_length, char_byte);
        FIELD_PRICE: begin
          if (char_byte == CHAR_DOT && !line_st.dot_seen) begin
            // Close the integer part and scale it to cents
            if (price_code != RSN_NONE)
              after_byte.errs[6] = line_st.errs[6] | price_code;
            else if (line_st.accum > PRICE_DOT_MAX)
              after_byte.errs[6] = line_st.errs[6] | RSN_RANGE;
            else
              after_byte.saved_price = price_v * 64'd100;
            after_byte.accum       = '0;
            after_byte.flags       = '0;
            after_byte.frac_digits = '0;
            after_byte.dot_seen    = 1'b1;
          end else begin
            after_byte.accum = acc_next;
            after_byte.flags = flg_next;
            if (line_st.dot_seen && line_st.frac_digits < 2'd3)
              after_byte.frac_digits = line_st.frac_digits + 2'd1;
          end
        end
        default: ;
      endcase
      if (line_st.field_length < 4'd15)
        after_byte.field_length = line_st.field_length + 4'd1;
    end
  end

  // The last byte also closes whatever field is open
  assign at_end = field_finish(after_byte);
  assign count  = {1'b0, at_end.field_index} + 5'd1;

  // Decide the line outcome in the fixed check order
  always_comb begin
    kind_next     = KIND_REJECT;
    reason_next   = RSN_NONE;
    id_known_next = 1'b0;
    order_id_next = '0;
    side_next     = 1'b0;
    limit_next    = 1'b0;
    qty_next      = '0;
    price_next    = '0;
    chars_next    = '0;
    symlen_next   = '0;
    session_next  = '0;
    if (at_end.head_match == MATCH_SECOND) begin
      if (count < 5'd2) reason_next = RSN_COUNT;
      else if (at_end.errs[1] != RSN_NONE) reason_next = at_end.errs[1];
      else if (count != 5'd2) begin
        reason_next   = RSN_COUNT;
        id_known_next = 1'b1;
        order_id_next = at_end.saved_id;
      end else begin
        kind_next     = KIND_CANCEL;
        id_known_next = 1'b1;
        order_id_next = at_end.saved_id;
        session_next  = session_id;
      end
    end else if (at_end.head_match != MATCH_FIRST) begin
      reason_next = RSN_UNKNOWN;
    end else if (count < 5'd2) begin
      reason_next = RSN_COUNT;
    end else if (at_end.errs[1] != RSN_NONE) begin
      reason_next = at_end.errs[1];
    end else begin
      id_known_next = 1'b1;
      order_id_next = at_end.saved_id;
      if (count < 5'd5) reason_next = RSN_COUNT;
      else if (at_end.errs[2] != RSN_NONE) reason_next = at_end.errs[2];
      else if (at_end.errs[4] != RSN_NONE) reason_next = at_end.errs[4];
      else if (count != (at_end.limit_seen ? 5'd7 : 5'd6)) reason_next = RSN_COUNT;
      else if (at_end.errs[3] != RSN_NONE) reason_next = at_end.errs[3];
      else if (at_end.errs[5] != RSN_NONE) reason_next = at_end.errs[5];
      else if (at_end.limit_seen && at_end.errs[6] != RSN_NONE)
        reason_next = at_end.errs[6];
      else begin
        kind_next    = KIND_NEW;
        side_next    = at_end.sell_seen;
        limit_next   = at_end.limit_seen;
        qty_next     = at_end.saved_qty;
        price_next   = at_end.limit_seen ? at_end.saved_price : 64'd0;
        chars_next   = at_end.symbols;
        symlen_next  = at_end.symbol_count;
        session_next = session_id;
      end
    end
  end

  // Drop all line state after the last byte
  assign line_next = last_byte ? line_clear() : after_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_st <= line_clear();
    end else if (accept) begin
      line_st <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; loaded only when a line completes
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      kind          <= kind_next;
      reason        <= reason_next;
      id_known      <= id_known_next;
      order_id      <= order_id_next;
      side_sell     <= side_next;
      is_limit      <= limit_next;
      quantity      <= qty_next;
      price_cents   <= price_next;
      symbol_chars  <= chars_next;
      symbol_length <= symlen_next;
      session_out   <= session_next;
    end
  end

endmodule
